// ----- rtl/macfwd_pkg.sv -----
// ----------------------------------------------------------------------------
// macfwd_pkg
// Shared types and codes for the MAC learning forwarding block.
// ----------------------------------------------------------------------------
`default_nettype none

package macfwd_pkg;

   localparam int MacWidth  = 48;
   localparam int PortWidth = 3;
   localparam int MaskWidth = 8;

   typedef logic [MacWidth-1:0]  mac_type;
   typedef logic [PortWidth-1:0] port_type;
   typedef logic [MaskWidth-1:0] mask_type;
   typedef logic [1:0]           action_type;

   localparam action_type ACT_FORWARD = 2'd0;
   localparam action_type ACT_FLOOD   = 2'd1;
   localparam action_type ACT_DROP    = 2'd2;

   typedef struct packed {
      mac_type  mac;
      port_type port;
   } entry_type;

   typedef struct packed {
      action_type action;
      port_type   egress_port;
      mask_type   flood_mask;
      logic       learned;
      logic       table_full;
   } result_type;

endpackage

`default_nettype wire

// ----- rtl/macfwd_table.sv -----
// ----------------------------------------------------------------------------
// macfwd_table
// Single-port-write, single-port-read synchronous MAC table with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module macfwd_table #(
   parameter int TABLE_DEPTH = 64,
   parameter int AW          = 6
) (
   input  wire                        clock,
   input  wire                        wr_en,
   input  wire [AW-1:0]               wr_addr,
   input  wire macfwd_pkg::entry_type wr_data,
   input  wire                        rd_en,
   input  wire [AW-1:0]               rd_addr,
   output macfwd_pkg::entry_type      rd_data
);

   macfwd_pkg::entry_type mem_ff [TABLE_DEPTH];
   macfwd_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/macfwd_ctrl.sv -----
// ----------------------------------------------------------------------------
// macfwd_ctrl
// Scan sequencer: walks the valid entries, resolves source and destination,
// learns the source and builds the forwarding result.
// ----------------------------------------------------------------------------
`default_nettype none

module macfwd_ctrl #(
   parameter int NUM_PORTS   = 8,
   parameter int TABLE_DEPTH = 64,
   parameter int AW          = 6,
   parameter int CW          = 7
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  wire macfwd_pkg::mac_type    req_src_mac,
   input  wire macfwd_pkg::mac_type    req_dst_mac,
   input  wire macfwd_pkg::port_type   req_ingress_port,
   input  wire macfwd_pkg::mask_type   blocked_ports,
   input  wire                         out_free,
   output logic                        res_load,
   output macfwd_pkg::result_type      res_data,
   output logic                        wr_en,
   output logic [AW-1:0]               wr_addr,
   output macfwd_pkg::entry_type       wr_data,
   output logic                        rd_en,
   output logic [AW-1:0]               rd_addr,
   input  wire macfwd_pkg::entry_type  rd_data
);

   localparam logic [CW-1:0] DepthVal = CW'(TABLE_DEPTH);
   localparam macfwd_pkg::mask_type PortSetMask =
      (NUM_PORTS >= 8) ? 8'hFF : 8'((1 << NUM_PORTS) - 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          addr_ff, addr_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic                   src_hit_ff, src_hit_in;
   logic                   dst_hit_ff, dst_hit_in;
   macfwd_pkg::port_type   dst_port_ff, dst_port_in;
   macfwd_pkg::mac_type    src_ff, dst_ff;
   macfwd_pkg::port_type   ing_ff;

   logic                   accept;
   logic                   scan_more;
   logic                   has_room;
   logic                   learn;
   logic                   dst_found;
   macfwd_pkg::port_type   dst_port;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign scan_more = (addr_ff < count_ff);
   assign has_room  = (count_ff < DepthVal);

   assign rd_en   = (state_ff == ST_SCAN) && scan_more;
   assign rd_addr = addr_ff[AW-1:0];

   // Learn decision and post-learn destination lookup
   assign learn     = !src_hit_ff && has_room;
   assign dst_found = dst_hit_ff || (learn && (dst_ff == src_ff));
   assign dst_port  = dst_hit_ff ? dst_port_ff : ing_ff;

   assign res_load = (state_ff == ST_DONE) && out_free;
   assign wr_en    = res_load && learn;
   assign wr_addr  = count_ff[AW-1:0];
   assign wr_data  = '{mac: src_ff, port: ing_ff};

   always_comb begin
      res_data             = '0;
      res_data.learned     = learn;
      res_data.table_full  = !src_hit_ff && !has_room;
      if (dst_found) begin
         if ((dst_port == ing_ff) || blocked_ports[dst_port]) begin
            res_data.action = macfwd_pkg::ACT_DROP;
         end else begin
            res_data.action      = macfwd_pkg::ACT_FORWARD;
            res_data.egress_port = dst_port;
         end
      end else begin
         res_data.action     = macfwd_pkg::ACT_FLOOD;
         res_data.flood_mask = PortSetMask & ~blocked_ports
                               & ~(macfwd_pkg::mask_type'(1) << ing_ff);
      end
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      addr_in     = addr_ff;
      src_hit_in  = src_hit_ff;
      dst_hit_in  = dst_hit_ff;
      dst_port_in = dst_port_ff;
      rd_vld_in   = rd_en;

      // Compare the entry read last cycle
      if (rd_vld_ff) begin
         if (rd_data.mac == src_ff) begin
            src_hit_in = 1'b1;
         end
         if (!dst_hit_ff && (rd_data.mac == dst_ff)) begin
            dst_hit_in  = 1'b1;
            dst_port_in = rd_data.port;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               addr_in    = '0;
               src_hit_in = 1'b0;
               dst_hit_in = 1'b0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_more) begin
               addr_in = addr_ff + CW'(1);
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (res_load) begin
               if (learn) begin
                  count_in = count_ff + CW'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      src_hit_ff  <= src_hit_in;
      dst_hit_ff  <= dst_hit_in;
      dst_port_ff <= dst_port_in;
      if (accept) begin
         src_ff <= req_src_mac;
         dst_ff <= req_dst_mac;
         ing_ff <= req_ingress_port;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/mac_learning_switch_forward.sv -----
// ----------------------------------------------------------------------------
// mac_learning_switch_forward
// Sequence: one request at a time; the scan walks every entry below the count
//   through the single read port of the MAC table memory, then a drain and a
//   done state follow; the result loads once the output register is free.
// Overlap: a finished result waits in the output register while the next
//   request is taken.
// Reset: synchronous, active high; clears the entry count, blocked mask and
//   handshake state. The table itself is not cleared; only written entries
//   below the count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module mac_learning_switch_forward #(
   parameter int NUM_PORTS   = 8,
   parameter int TABLE_DEPTH = 64
) (
   input  wire                   clock,
   input  wire                   reset,
   // request channel
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire [47:0]            req_src_mac,
   input  wire [47:0]            req_dst_mac,
   input  wire [2:0]             req_ingress_port,
   // response channel
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output logic [1:0]            rsp_action,
   output logic [2:0]            rsp_egress_port,
   output logic [7:0]            rsp_flood_mask,
   output logic                  rsp_learned,
   output logic                  rsp_table_full,
   // configuration write channel
   input  wire                   csr_valid,
   output logic                  csr_ready,
   input  wire [7:0]             csr_blocked_ports
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   macfwd_pkg::mask_type   blocked_ff;
   logic                   rsp_valid_ff;
   macfwd_pkg::result_type rsp_data_ff;

   logic                   out_free;
   logic                   res_load;
   macfwd_pkg::result_type res_data;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   macfwd_pkg::entry_type  wr_data;
   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   macfwd_pkg::entry_type  rd_data;

   // Configuration: always ready, take the mask on each write transaction.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         blocked_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         blocked_ff <= csr_blocked_ports;
      end
   end

   // Output register: free when empty or being drained this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_action      = rsp_data_ff.action;
   assign rsp_egress_port = rsp_data_ff.egress_port;
   assign rsp_flood_mask  = rsp_data_ff.flood_mask;
   assign rsp_learned     = rsp_data_ff.learned;
   assign rsp_table_full  = rsp_data_ff.table_full;

   // Scan sequencer: reads the table, learns, and builds the result.
   macfwd_ctrl #(
      .NUM_PORTS   (NUM_PORTS),
      .TABLE_DEPTH (TABLE_DEPTH),
      .AW          (AW),
      .CW          (CW)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_src_mac      (req_src_mac),
      .req_dst_mac      (req_dst_mac),
      .req_ingress_port (req_ingress_port),
      .blocked_ports    (blocked_ff),
      .out_free         (out_free),
      .res_load         (res_load),
      .res_data         (res_data),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .rd_en            (rd_en),
      .rd_addr          (rd_addr),
      .rd_data          (rd_data)
   );

   // MAC table memory; writes happen only after the scan has finished.
   macfwd_table #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .AW          (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

`default_nettype wire
